### src/persistent_array_versions_top_macros.svh
// Assertion macros for the versioned array store.
// Taken in by persistent_array_versions_top.sv; no other dependencies.
`ifndef PERSISTENT_ARRAY_VERSIONS_TOP_MACROS_SVH
`define PERSISTENT_ARRAY_VERSIONS_TOP_MACROS_SVH

// Implication checked from the same edge.
`define PAV_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pav check failed");

// Implication checked at the next edge.
`define PAV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pav check failed");

`endif

### src/pav_pkg.sv
// Shared codes and item layouts for the versioned array store.
// No dependencies.
package pav_pkg;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_UPDATE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  localparam logic [1:0] ST_LOADED  = 2'd0;
  localparam logic [1:0] ST_UPDATED = 2'd1;
  localparam logic [1:0] ST_QUERIED = 2'd2;
  localparam logic [1:0] ST_ERROR   = 2'd3;

  localparam int IDX_W = 11;
  localparam int VER_W = 10;
  localparam int VAL_W = 32;

  localparam logic [IDX_W-1:0] SIZE_RESET = 11'd1024;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
    logic [VER_W-1:0] base_version;
    logic [1:0]       mode;
  } in_item_t;

  typedef struct packed {
    logic [VER_W-1:0] new_version;
    logic [1:0]       status;
    logic [VAL_W-1:0] read_value;
  } out_item_t;

endpackage

### src/persistent_array_versions_top.sv
// Versioned array store (persistent segment tree with path copying).
// Depends on pav_pkg and persistent_array_versions_top_macros.svh.
//
// Usage:
//   in_*  : stream of items {mode, base_version, index, value}; every item
//           gives exactly one result item on out_* {read_value, status,
//           new_version}.
//   cfg_* : APB-style port, register 0 (byte address 0) is array_size.
//           Writes are ignored once the first update or query has closed
//           loading. Write it only while the block is idle.
//   Load items write version 0 into the staged element memory. Version 0 is
//   never built node by node: its nodes are implicit, and links marked as
//   original fall through to the staged element memory.
//   Update and query walk down one tree level per S_STEP/S_DATA pair (one
//   node memory read, then one node write for updates). After an item is
//   taken the walk runs S_ROOT, then S_STEP and S_DATA for each level, and
//   the result moves on to S_PUSH; the next item is taken only once S_PUSH
//   has returned to S_IDLE. One item is in work at a time; in_tready is low
//   while a walk runs. The result sits in an output register; the next
//   item is taken while it waits, and a second finished result waits for
//   out_tready. After reset the staged element memory is cleared, one
//   entry per cycle, all MAX_ELEMENTS + 1 entries; in_tready stays low
//   meanwhile while configuration writes are taken as usual.
module persistent_array_versions_top #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int MAX_VERSIONS = 1024,
  parameter int POOL_NODES   = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] mode, [11:2] base_version, [22:12] index, [54:23] value, [55] ignored
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] read_value, [33:32] status, [43:34] new_version, [47:44] zero
  output logic [47:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

`include "persistent_array_versions_top_macros.svh"

  localparam int IW   = pav_pkg::IDX_W;
  localparam int SA_W = $clog2(MAX_ELEMENTS + 1);
  localparam int RW   = $clog2(MAX_VERSIONS);
  localparam int VW   = $clog2(MAX_VERSIONS + 1);
  localparam int PIW  = $clog2(POOL_NODES);
  localparam int NW   = $clog2(POOL_NODES + 1);
  localparam int PW   = PIW + 1;

  localparam logic [PW-1:0] ORIG = {1'b1, {PIW{1'b0}}};
  localparam logic [IW-1:0] SIZE_INIT =
    (32'(pav_pkg::SIZE_RESET) > 32'(MAX_ELEMENTS)) ? IW'(MAX_ELEMENTS) : pav_pkg::SIZE_RESET;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_ROOT = 3'd2;
  localparam logic [2:0] S_STEP = 3'd3;
  localparam logic [2:0] S_DATA = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;

  logic [2:0]    st_r;
  logic [SA_W-1:0] clr_r;
  logic [IW-1:0] size_r;
  logic          closed_r;
  logic [NW-1:0] nodes_r;
  logic [VW-1:0] vers_r;

  logic [1:0]    mode_r;
  logic [IW-1:0] pos_r, lo_r, hi_r;
  logic [31:0]   val_r;
  logic [PW-1:0] node_r, root_r;
  logic          root_orig_r;
  logic [NW-1:0] cur_r, start_r;
  logic [VW-1:0] nv_r;

  logic [31:0]   res_val_r;
  logic [1:0]    res_st_r;
  logic [VW-1:0] res_nv_r;

  logic          out_valid_r;
  pav_pkg::out_item_t out_r;

  // memories
  logic [31:0]   staged   [MAX_ELEMENTS+1];
  logic [PW-1:0] roots    [MAX_VERSIONS];
  logic [PW-1:0] left_m   [POOL_NODES];
  logic [PW-1:0] right_m  [POOL_NODES];
  logic [31:0]   leaf_m   [POOL_NODES];
  logic [31:0]   stg_q, leaf_q;
  logic [PW-1:0] root_q, left_q, right_q;

  pav_pkg::in_item_t in_item;
  logic          in_acc, cfg_wr;
  logic [31:0]   build_nodes;
  logic          bad_pos;
  logic [VW-1:0] eff_vers;
  logic [NW-1:0] eff_nodes;
  logic [IW:0]   sum;
  logic [IW-1:0] mid;
  logic          go_left, is_leaf, cur_ok;
  logic [PW-1:0] pl, pr, child_ptr;

  logic          stg_we;
  logic [SA_W-1:0] stg_wa;
  logic [31:0]   stg_wd;
  logic          roots_we;
  logic [RW-1:0] roots_wa;
  logic [PW-1:0] roots_wd;
  logic          node_we;

  assign in_item    = pav_pkg::in_item_t'(in_tdata[54:0]);
  assign in_tready  = (st_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? 32'(size_r) : 32'd0;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_r};

  assign build_nodes = (32'(size_r) << 1) - 32'd1;
  assign bad_pos     = (in_item.index == '0) || (in_item.index > size_r);
  assign eff_vers    = closed_r ? vers_r : VW'(1);
  assign eff_nodes   = closed_r ? nodes_r : NW'(build_nodes);

  assign sum     = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = sum[IW:1];
  assign go_left = (pos_r <= mid);
  assign is_leaf = (lo_r == hi_r);
  assign cur_ok  = (cur_r < NW'(POOL_NODES));
  // an original node has original children
  assign pl        = node_r[PW-1] ? ORIG : left_q;
  assign pr        = node_r[PW-1] ? ORIG : right_q;
  assign child_ptr = {1'b0, PIW'(cur_r + NW'(1))};

  // memory write ports
  always_comb begin
    stg_we   = 1'b0;
    stg_wa   = clr_r;
    stg_wd   = 32'd0;
    roots_we = 1'b0;
    roots_wa = '0;
    roots_wd = ORIG;
    if (st_r == S_CLR) begin
      stg_we = 1'b1;
    end else if (in_acc && !bad_pos && in_item.mode == pav_pkg::MODE_LOAD && !closed_r) begin
      stg_we = 1'b1;
      stg_wa = SA_W'(in_item.index);
      stg_wd = in_item.value;
    end
    if (in_acc && !bad_pos && !closed_r && build_nodes <= 32'(POOL_NODES) &&
        (in_item.mode == pav_pkg::MODE_UPDATE || in_item.mode == pav_pkg::MODE_QUERY)) begin
      roots_we = 1'b1;
    end else if (st_r == S_DATA && is_leaf) begin
      if (mode_r == pav_pkg::MODE_QUERY) begin
        roots_we = 1'b1;
        roots_wa = RW'(nv_r);
        roots_wd = root_r;
      end else if (cur_ok) begin
        roots_we = 1'b1;
        roots_wa = RW'(nv_r);
        roots_wd = {1'b0, start_r[PIW-1:0]};
      end
    end
  end

  assign node_we = (st_r == S_DATA) && (mode_r == pav_pkg::MODE_UPDATE) && cur_ok;

  always_ff @(posedge clk) begin
    if (stg_we) staged[stg_wa] <= stg_wd;
    if (st_r == S_STEP) stg_q <= staged[SA_W'(pos_r)];
  end

  always_ff @(posedge clk) begin
    if (roots_we) roots[roots_wa] <= roots_wd;
    if (in_acc) root_q <= roots[RW'(in_item.base_version)];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      left_m[cur_r[PIW-1:0]]  <= (!is_leaf && go_left) ? child_ptr : pl;
      right_m[cur_r[PIW-1:0]] <= (!is_leaf && !go_left) ? child_ptr : pr;
      leaf_m[cur_r[PIW-1:0]]  <= val_r;
    end
    if (st_r == S_STEP) begin
      left_q  <= left_m[node_r[PIW-1:0]];
      right_q <= right_m[node_r[PIW-1:0]];
      leaf_q  <= leaf_m[node_r[PIW-1:0]];
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_INIT;
    end else if (cfg_wr && cfg_paddr[2] == 1'b0 && !closed_r) begin
      if (cfg_pwdata[IW-1:0] == '0) begin
        size_r <= IW'(1);
      end else if (32'(cfg_pwdata[IW-1:0]) > 32'(MAX_ELEMENTS)) begin
        size_r <= IW'(MAX_ELEMENTS);
      end else begin
        size_r <= cfg_pwdata[IW-1:0];
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      clr_r       <= '0;
      closed_r    <= 1'b0;
      nodes_r     <= '0;
      vers_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && st_r != S_PUSH) out_valid_r <= 1'b0;
      case (st_r)
        S_CLR: begin
          clr_r <= clr_r + SA_W'(1);
          if (clr_r == SA_W'(MAX_ELEMENTS)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            mode_r      <= in_item.mode;
            pos_r       <= in_item.index;
            val_r       <= in_item.value;
            lo_r        <= IW'(1);
            hi_r        <= size_r;
            root_orig_r <= !closed_r;
            cur_r       <= eff_nodes;
            start_r     <= eff_nodes;
            nv_r        <= eff_vers;
            res_val_r   <= 32'd0;
            res_st_r    <= pav_pkg::ST_ERROR;
            res_nv_r    <= '0;
            st_r        <= S_PUSH;
            if (!bad_pos) begin
              if (in_item.mode == pav_pkg::MODE_LOAD) begin
                if (!closed_r) res_st_r <= pav_pkg::ST_LOADED;
              end else if (in_item.mode == pav_pkg::MODE_UPDATE ||
                           in_item.mode == pav_pkg::MODE_QUERY) begin
                if (closed_r || build_nodes <= 32'(POOL_NODES)) begin
                  closed_r <= 1'b1;
                  nodes_r  <= eff_nodes;
                  vers_r   <= eff_vers;
                  if (32'(in_item.base_version) < 32'(eff_vers) &&
                      32'(eff_vers) < 32'(MAX_VERSIONS)) begin
                    st_r <= S_ROOT;
                  end
                end
              end
            end
          end
        end
        S_ROOT: begin
          node_r <= root_orig_r ? ORIG : root_q;
          root_r <= root_orig_r ? ORIG : root_q;
          st_r   <= S_STEP;
        end
        S_STEP: begin
          st_r <= S_DATA;
        end
        S_DATA: begin
          if (mode_r == pav_pkg::MODE_UPDATE && !cur_ok) begin
            // pool full: drop the partial path
            st_r <= S_PUSH;
          end else if (is_leaf) begin
            vers_r   <= nv_r + VW'(1);
            res_nv_r <= nv_r;
            if (mode_r == pav_pkg::MODE_QUERY) begin
              res_val_r <= node_r[PW-1] ? stg_q : leaf_q;
              res_st_r  <= pav_pkg::ST_QUERIED;
            end else begin
              nodes_r  <= cur_r + NW'(1);
              res_st_r <= pav_pkg::ST_UPDATED;
            end
            st_r <= S_PUSH;
          end else begin
            node_r <= go_left ? pl : pr;
            if (go_left) hi_r <= mid;
            else lo_r <= mid + IW'(1);
            cur_r <= cur_r + NW'(1);
            st_r  <= S_STEP;
          end
        end
        S_PUSH: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r       <= 1'b1;
            out_r.read_value  <= res_val_r;
            out_r.status      <= res_st_r;
            out_r.new_version <= pav_pkg::VER_W'(res_nv_r);
            st_r              <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `PAV_ASSERT_NEXT(a_closed_sticky, clk, rst_n, closed_r, closed_r)
  `PAV_ASSERT_SAME(a_open_no_versions, clk, rst_n, !closed_r, vers_r == '0 && nodes_r == '0)
  `PAV_ASSERT_SAME(a_pool_bound, clk, rst_n, 1'b1, nodes_r <= NW'(POOL_NODES))
  `PAV_ASSERT_SAME(a_error_zero, clk, rst_n, out_valid_r && out_r.status == pav_pkg::ST_ERROR, out_r.read_value == 32'd0 && out_r.new_version == '0)
  `PAV_ASSERT_NEXT(a_vers_grow, clk, rst_n, closed_r, vers_r >= $past(vers_r))

endmodule
